FILE: hw/rtl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MODE_W   = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRUNCATE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [VAL_W-1:0] value_in;
        logic [POS_W-1:0]        position;
    } op_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] value_out;
        logic [LEN_W-1:0]        length;
        logic                    is_empty;
    } res_beat_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/bdq_ctrl.sv
// Sequencing state machine for the double-ended queue.
`timescale 1ns / 1ps

module bdq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  bdq_pkg::dp_status_t   dp_status,
    output bdq_pkg::dp_cmd_t      dp_cmd
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign op_ready       = (state_reg == S_IDLE);
    assign dp_cmd.capture = (state_reg == S_IDLE) && op_valid;
    assign dp_cmd.exec    = (state_reg == S_EXEC);
    assign dp_cmd.load    = (state_reg == S_FINISH) && dp_status.out_free;

endmodule

FILE: hw/rtl/bdq_datapath.sv
// Ring buffer, pointers and result register for the double-ended queue.
`timescale 1ns / 1ps

module bdq_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bdq_pkg::dp_cmd_t     dp_cmd,
    output bdq_pkg::dp_status_t  dp_status,
    input  bdq_pkg::op_beat_t    op,
    output logic                 res_valid,
    input  logic                 res_ready,
    output bdq_pkg::res_beat_t   res
);

    localparam int DEPTH = bdq_pkg::DEPTH;
    localparam int IDX_W = bdq_pkg::IDX_W;
    localparam int CNT_W = bdq_pkg::CNT_W;
    localparam int VAL_W = bdq_pkg::VAL_W;
    localparam int LEN_W = bdq_pkg::LEN_W;
    localparam int CMP_W = bdq_pkg::CMP_W;

    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W:0]   off);
        logic [IDX_W+1:0] sum;
        sum = {2'b00, base} + {1'b0, off};
        if (sum >= (IDX_W+2)'(DEPTH))
        begin
            sum = sum - (IDX_W+2)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [VAL_W-1:0] mem [DEPTH];

    bdq_pkg::op_beat_t          op_reg;
    logic [IDX_W-1:0]           front_reg;
    logic [IDX_W-1:0]           front_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [bdq_pkg::STATUS_W-1:0] status_reg;
    logic [bdq_pkg::STATUS_W-1:0] status_next;
    logic                       pop_reg;
    logic                       pop_next;
    logic [VAL_W-1:0]           rd_data_reg;
    logic                       we;
    logic [IDX_W-1:0]           waddr;
    logic [IDX_W-1:0]           raddr;
    logic                       full;
    logic                       empty;
    logic [CMP_W-1:0]           pos_ext;
    logic [CMP_W-1:0]           cnt_ext;
    logic                       out_valid_reg;
    bdq_pkg::res_beat_t         out_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(op_reg.position);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = bdq_pkg::STATUS_OK;
        pop_next    = 1'b0;
        we          = 1'b0;
        waddr       = front_reg;
        raddr       = front_reg;
        case (op_reg.mode)
            bdq_pkg::MODE_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = bdq_pkg::STATUS_FULL;
                end
                else
                begin
                    front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
                    waddr      = front_next;
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdq_pkg::MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = bdq_pkg::STATUS_FULL;
                end
                else
                begin
                    waddr      = slot_add(front_reg, (IDX_W+1)'(count_reg));
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdq_pkg::MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = bdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    raddr      = front_reg;
                    pop_next   = 1'b1;
                    front_next = slot_add(front_reg, (IDX_W+1)'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            bdq_pkg::MODE_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = bdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    raddr      = slot_add(front_reg, (IDX_W+1)'(count_reg - 1'b1));
                    pop_next   = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            bdq_pkg::MODE_TRUNCATE:
            begin
                if (pos_ext < cnt_ext)
                begin
                    count_next = CNT_W'(pos_ext);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            if (we)
            begin
                mem[waddr] <= op_reg.value_in;
            end
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg <= op;
        end
        if (dp_cmd.exec)
        begin
            status_reg <= status_next;
            pop_reg    <= pop_next;
        end
        if (dp_cmd.load)
        begin
            out_reg.status    <= status_reg;
            out_reg.value_out <= pop_reg ? rd_data_reg : '0;
            out_reg.length    <= LEN_W'(count_reg);
            out_reg.is_empty  <= (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.exec)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (dp_cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dp_status.out_free = !out_valid_reg || res_ready;
    assign res_valid          = out_valid_reg;
    assign res                = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg < IDX_W'(DEPTH - 1) || front_reg == IDX_W'(DEPTH - 1))
        else $error("front index outside ring");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.is_empty == (out_reg.length == '0)))
        else $error("empty flag disagrees with length");

    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != bdq_pkg::STATUS_OK) |-> (out_reg.value_out == '0))
        else $error("failed operation returned a value");

endmodule

FILE: hw/rtl/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue.
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit values in a ring buffer of bdq_pkg::DEPTH entries.
// Each accepted op beat gives exactly one res beat. An operation passes through accept,
// execute (pointer update, a read of the ring memory and, on a push, a write to it),
// then load of the result register, whose read data is registered. The load waits
// until the result register is free, and no new op beat is accepted before the last
// one has been loaded. No clearing pass after reset.

module bounded_double_ended_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  bdq_pkg::op_beat_t  op,
    output logic               res_valid,
    input  logic               res_ready,
    output bdq_pkg::res_beat_t res
);

    bdq_pkg::dp_cmd_t    dp_cmd;
    bdq_pkg::dp_status_t dp_status;

    bdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    bdq_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

FILE: test/bdq_checker.sv
// Checker for the bounded double-ended queue: tracks deque contents and compares every result beat.
`timescale 1ns / 1ps

module bdq_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  logic               op_ready,
    input  bdq_pkg::op_beat_t  op,
    input  logic               res_valid,
    input  logic               res_ready,
    input  bdq_pkg::res_beat_t res,
    output int                 fail_count,
    output int                 owed
);

    localparam int DEPTH = bdq_pkg::DEPTH;
    localparam int IDX_W = bdq_pkg::IDX_W;
    localparam int CNT_W = bdq_pkg::CNT_W;
    localparam int VAL_W = bdq_pkg::VAL_W;
    localparam int LEN_W = bdq_pkg::LEN_W;
    localparam int CMP_W = bdq_pkg::CMP_W;

    logic signed [VAL_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]        head = '0;
    logic [CNT_W-1:0]        fill = '0;
    bdq_pkg::res_beat_t      owed_results [$];
    int                      fails = 0;

    function automatic bdq_pkg::res_beat_t predict_result(input bdq_pkg::op_beat_t b);
        bdq_pkg::res_beat_t r;
        r        = '0;
        r.status = bdq_pkg::STATUS_OK;
        case (b.mode)
            bdq_pkg::MODE_PUSH_FRONT:
            begin
                if (fill == CNT_W'(DEPTH))
                    r.status = bdq_pkg::STATUS_FULL;
                else
                begin
                    head       = IDX_W'((int'(head) + DEPTH - 1) % DEPTH);
                    ring[head] = b.value_in;
                    fill       = fill + 1'b1;
                end
            end
            bdq_pkg::MODE_PUSH_BACK:
            begin
                if (fill == CNT_W'(DEPTH))
                    r.status = bdq_pkg::STATUS_FULL;
                else
                begin
                    ring[IDX_W'((int'(head) + int'(fill)) % DEPTH)] = b.value_in;
                    fill = fill + 1'b1;
                end
            end
            bdq_pkg::MODE_POP_FRONT:
            begin
                if (fill == '0)
                    r.status = bdq_pkg::STATUS_EMPTY;
                else
                begin
                    r.value_out = ring[head];
                    head        = IDX_W'((int'(head) + 1) % DEPTH);
                    fill        = fill - 1'b1;
                end
            end
            bdq_pkg::MODE_POP_BACK:
            begin
                if (fill == '0)
                    r.status = bdq_pkg::STATUS_EMPTY;
                else
                begin
                    r.value_out = ring[IDX_W'((int'(head) + int'(fill) - 1) % DEPTH)];
                    fill        = fill - 1'b1;
                end
            end
            bdq_pkg::MODE_TRUNCATE:
            begin
                if (CMP_W'(b.position) < CMP_W'(fill))
                    fill = CNT_W'(b.position);
            end
            default:
            begin
            end
        endcase
        r.length   = LEN_W'(fill);
        r.is_empty = (fill == '0);
        return r;
    endfunction

    always @(posedge clk)
    begin
        bdq_pkg::res_beat_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%t unexpected beat st/val/len/emp %0d/%0d/%0d/%0b",
                                 $realtime, res.status, res.value_out, res.length,
                                 res.is_empty);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (res.status !== want.status || res.value_out !== want.value_out ||
                        res.length !== want.length || res.is_empty !== want.is_empty)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%t want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     $realtime, want.status, want.value_out, want.length,
                                     want.is_empty, res.status, res.value_out, res.length,
                                     res.is_empty);
                    end
                end
            end
            if (op_valid && op_ready)
                owed_results.push_back(predict_result(op));
            owed       <= owed_results.size();
            fail_count <= fails;
        end
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the bounded double-ended queue: clock, reset, op stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int                         MODE_W        = bdq_pkg::MODE_W;
    localparam int                         VAL_W         = bdq_pkg::VAL_W;
    localparam int                         POS_W         = bdq_pkg::POS_W;
    localparam logic [MODE_W-1:0]          MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0]          MODE_SPARE_HI = 3'd7;
    localparam int                         IDLE_PCT      = 16;
    localparam int                         RANDOM_OPS    = 1950;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               op_valid  = 1'b0;
    logic               res_ready = 1'b0;
    bdq_pkg::op_beat_t  op        = '0;
    logic               op_ready;
    logic               res_valid;
    bdq_pkg::res_beat_t res;
    int                 fail_count;
    int                 owed;
    bit                 steady    = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bounded_double_ended_queue i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    bdq_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .fail_count (fail_count),
        .owed       (owed)
    );

    always @(posedge clk)
        res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic signed [VAL_W-1:0] value,
                           input logic [POS_W-1:0] position);
        bdq_pkg::op_beat_t b;
        b.mode     = mode;
        b.value_in = value;
        b.position = position;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            op_valid <= 1'b0;
            @(posedge clk);
        end
        op_valid <= 1'b1;
        op       <= b;
        do
            @(posedge clk);
        while (!op_ready);
    endtask

    initial
    begin
        #10ms;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int                phase_len;
        int                push_pct;
        int                pop_pct;
        int                trunc_pct;
        int                r;
        int                sent;
        logic [MODE_W-1:0] m;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-queue pops, truncate on empty, extremes, spare modes, truncate edges
        send_op(bdq_pkg::MODE_POP_FRONT, 0, 0);
        send_op(bdq_pkg::MODE_POP_BACK, 0, 0);
        send_op(bdq_pkg::MODE_TRUNCATE, 0, 0);
        send_op(bdq_pkg::MODE_QUERY, 0, 0);
        send_op(bdq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 0);
        send_op(bdq_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF, 7'h7F);
        send_op(bdq_pkg::MODE_PUSH_FRONT, -1, 0);
        send_op(bdq_pkg::MODE_PUSH_BACK, 0, 0);
        send_op(MODE_SPARE_LO, 32'h5A5A_A5A5, 7'h55);
        send_op(MODE_SPARE_HI, 32'hA5A5_5A5A, 7'h2A);
        send_op(bdq_pkg::MODE_TRUNCATE, 0, 7'd127);
        send_op(bdq_pkg::MODE_TRUNCATE, 0, 7'd64);
        send_op(bdq_pkg::MODE_TRUNCATE, 0, 7'd4);
        send_op(bdq_pkg::MODE_TRUNCATE, 0, 7'd3);
        send_op(bdq_pkg::MODE_POP_FRONT, 0, 0);
        send_op(bdq_pkg::MODE_POP_BACK, 0, 0);
        send_op(bdq_pkg::MODE_PUSH_BACK, 32'h1234_5678, 0);
        send_op(bdq_pkg::MODE_TRUNCATE, 0, 0);
        send_op(bdq_pkg::MODE_POP_BACK, 0, 0);
        send_op(bdq_pkg::MODE_QUERY, -1, 7'h7F);

        sent = 0;
        while (sent < RANDOM_OPS)
        begin
            steady <= (sent >= 600 && sent < 1000);
            case ($urandom_range(2))
                0:
                begin
                    push_pct  = 80;
                    pop_pct   = 12;
                    trunc_pct = 2;
                end
                1:
                begin
                    push_pct  = 15;
                    pop_pct   = 75;
                    trunc_pct = 5;
                end
                default:
                begin
                    push_pct  = 45;
                    pop_pct   = 40;
                    trunc_pct = 8;
                end
            endcase
            phase_len = $urandom_range(40, 200);
            if (phase_len > RANDOM_OPS - sent)
                phase_len = RANDOM_OPS - sent;
            repeat (phase_len)
            begin
                r = $urandom_range(99);
                if (r < push_pct)
                    m = $urandom_range(1) ? bdq_pkg::MODE_PUSH_BACK : bdq_pkg::MODE_PUSH_FRONT;
                else if (r < push_pct + pop_pct)
                    m = $urandom_range(1) ? bdq_pkg::MODE_POP_BACK : bdq_pkg::MODE_POP_FRONT;
                else if (r < push_pct + pop_pct + trunc_pct)
                    m = bdq_pkg::MODE_TRUNCATE;
                else if ($urandom_range(3) == 0)
                    m = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
                else
                    m = bdq_pkg::MODE_QUERY;
                send_op(m, $urandom(),
                        (m == bdq_pkg::MODE_TRUNCATE && $urandom_range(9) != 0) ?
                        POS_W'($urandom_range(64)) : POS_W'($urandom()));
                sent++;
            end
        end

        op_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
